### rtl/core/pcrt_pkg.sv
// shared types and constants for the pixel contrast and red tint block
package pcrt_pkg;

    localparam int CHAN_W    = 8;
    localparam int PCT_W     = 7;
    localparam int PROD_W    = 15;
    localparam int QUOT_W    = 9;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 8;

    // division by one hundred as multiply by reciprocal, exact for products below 2^15
    localparam int RECIP_W     = 13;
    localparam int RECIP_SHIFT = 19;
    localparam logic [RECIP_W-1:0] RECIP_100 = 13'd5243;

    localparam logic [PROD_W-1:0] CEIL_BIAS = 15'd99;
    localparam logic [CHAN_W-1:0] CHAN_MAX  = 8'd255;

    localparam logic [CFG_IDX_W-1:0] CFG_FILTER_MODE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PERCENT     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MID_LEVEL   = 2'd2;

    localparam logic MODE_CONTRAST = 1'b0;
    localparam logic MODE_RED_TINT = 1'b1;

    localparam logic [CHAN_W-1:0] MID_LEVEL_RST = 8'd127;

    // one channel between the multiply stage and the result stage
    typedef struct packed {
        logic [CHAN_W-1:0] value;
        logic [PROD_W-1:0] prod;
        logic              grow;
    } t_chan_prod;

endpackage

### rtl/core/pcrt_chan_mul.sv
// per-channel product of value and percent, biased for rounding up when shrinking
module pcrt_chan_mul (
    input  logic [pcrt_pkg::CHAN_W-1:0] i_value,
    input  logic [pcrt_pkg::PCT_W-1:0]  i_percent,
    input  logic                        i_grow,
    output pcrt_pkg::t_chan_prod        o_prod
);
    import pcrt_pkg::*;

    logic [PROD_W-1:0] w_prod;

    assign w_prod = PROD_W'(i_value) * PROD_W'(i_percent);

    always_comb begin
        o_prod.value = i_value;
        o_prod.grow  = i_grow;
        // ceil(x/100) is floor((x+99)/100)
        o_prod.prod  = i_grow ? w_prod : w_prod + CEIL_BIAS;
    end

endmodule

### rtl/core/pcrt_chan_out.sv
// per-channel divide by one hundred and saturating grow or shrink
module pcrt_chan_out (
    input  pcrt_pkg::t_chan_prod        i_prod,
    output logic [pcrt_pkg::CHAN_W-1:0] o_value
);
    import pcrt_pkg::*;

    localparam int FULL_W = PROD_W + RECIP_W;

    logic [FULL_W-1:0] w_full;
    logic [QUOT_W-1:0] w_quot;
    logic [QUOT_W:0]   w_sum;

    assign w_full = FULL_W'(i_prod.prod) * FULL_W'(RECIP_100);
    assign w_quot = w_full[RECIP_SHIFT +: QUOT_W];
    assign w_sum  = (QUOT_W+1)'(i_prod.value) + (QUOT_W+1)'(w_quot);

    always_comb begin
        if (i_prod.grow) begin
            o_value = (w_sum > (QUOT_W+1)'(CHAN_MAX)) ? CHAN_MAX : w_sum[CHAN_W-1:0];
        end else begin
            o_value = (w_quot >= QUOT_W'(i_prod.value)) ? '0
                    : i_prod.value - w_quot[CHAN_W-1:0];
        end
    end

endmodule

### rtl/core/pixel_contrast_and_red_tint.sv
// top level of the pixel contrast and red tint filter
//
// input channel: i_valid / o_ready with one bgr pixel word per handshake
// output channel: o_valid / i_ready with the adjusted bgr word
// config port: i_cfg_we, i_cfg_idx, i_cfg_data; 0 filter mode, 1 percent,
// 2 mid level; writes to other indexes are dropped, write only while idle
// three register stages: input capture, channel products, result
// a word accepted passes the capture and product registers before the result register offers it
// throughput: one word per cycle unless the receiver stalls, set by the
// three-stage pipeline with one multiplier per channel per stage
// o_ready is high whenever the output register is empty or taken this cycle,
// so a stalled receiver backs the pipe up one stage at a time
// reset clears all stage valid bits and loads filter mode 0, percent 0,
// mid level 127; output data holds while o_valid waits for i_ready
module pixel_contrast_and_red_tint (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [pcrt_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [pcrt_pkg::CFG_DAT_W-1:0]   i_cfg_data,
    input  logic                             i_valid,
    output logic                             o_ready,
    input  logic [pcrt_pkg::CHAN_W-1:0]      i_blue_in,
    input  logic [pcrt_pkg::CHAN_W-1:0]      i_green_in,
    input  logic [pcrt_pkg::CHAN_W-1:0]      i_red_in,
    output logic                             o_valid,
    input  logic                             i_ready,
    output logic [pcrt_pkg::CHAN_W-1:0]      o_blue_out,
    output logic [pcrt_pkg::CHAN_W-1:0]      o_green_out,
    output logic [pcrt_pkg::CHAN_W-1:0]      o_red_out
);
    import pcrt_pkg::*;

    localparam int SUM_W = CHAN_W + 2;

    // configuration registers
    logic              r_filter_mode;
    logic [PCT_W-1:0]  r_percent;
    logic [CHAN_W-1:0] r_mid_level;

    // stage valid bits
    logic r_v1, r_v2, r_v3;
    logic w_en1, w_en2, w_en3;

    // stage 1: captured pixel
    logic [CHAN_W-1:0] r_blue1, r_green1, r_red1;

    // stage 2: products
    t_chan_prod r_blue2, r_green2, r_red2;
    t_chan_prod n_blue2, n_green2, n_red2;

    // stage 3: results
    logic [CHAN_W-1:0] r_blue3, r_green3, r_red3;
    logic [CHAN_W-1:0] n_blue3, n_green3, n_red3;

    logic [SUM_W-1:0] w_sum;
    logic [SUM_W-1:0] w_thresh;
    logic             w_bright;
    logic             w_grow_rg;   // grow flag for red
    logic             w_grow_gb;   // grow flag for green and blue

    // a stage moves when the one after it is empty or moving
    assign w_en3   = !r_v3 || i_ready;
    assign w_en2   = !r_v2 || w_en3;
    assign w_en1   = !r_v1 || w_en2;
    assign o_ready = w_en1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_filter_mode <= MODE_CONTRAST;
            r_percent     <= '0;
            r_mid_level   <= MID_LEVEL_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_FILTER_MODE: r_filter_mode <= i_cfg_data[0];
                CFG_PERCENT:     r_percent     <= i_cfg_data[PCT_W-1:0];
                CFG_MID_LEVEL:   r_mid_level   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (w_en1) r_v1 <= i_valid;
            if (w_en2) r_v2 <= r_v1;
            if (w_en3) r_v3 <= r_v2;
        end
    end

    // floor(sum/3) > mid is the same as sum > 3*mid + 2
    assign w_sum    = SUM_W'(r_blue1) + SUM_W'(r_green1) + SUM_W'(r_red1);
    assign w_thresh = SUM_W'(r_mid_level) * SUM_W'(3) + SUM_W'(2);
    assign w_bright = w_sum > w_thresh;

    always_comb begin
        case (r_filter_mode)
            MODE_CONTRAST: begin
                w_grow_rg = w_bright;
                w_grow_gb = w_bright;
            end
            MODE_RED_TINT: begin
                w_grow_rg = 1'b1;
                w_grow_gb = 1'b0;
            end
            default: begin
                w_grow_rg = 1'b0;
                w_grow_gb = 1'b0;
            end
        endcase
    end

    pcrt_chan_mul u_mul_blue (
        .i_value(r_blue1), .i_percent(r_percent), .i_grow(w_grow_gb), .o_prod(n_blue2)
    );
    pcrt_chan_mul u_mul_green (
        .i_value(r_green1), .i_percent(r_percent), .i_grow(w_grow_gb), .o_prod(n_green2)
    );
    pcrt_chan_mul u_mul_red (
        .i_value(r_red1), .i_percent(r_percent), .i_grow(w_grow_rg), .o_prod(n_red2)
    );

    pcrt_chan_out u_out_blue  (.i_prod(r_blue2),  .o_value(n_blue3));
    pcrt_chan_out u_out_green (.i_prod(r_green2), .o_value(n_green3));
    pcrt_chan_out u_out_red   (.i_prod(r_red2),   .o_value(n_red3));

    // payload registers, no reset
    always_ff @(posedge i_clk) begin
        if (w_en1) begin
            r_blue1  <= i_blue_in;
            r_green1 <= i_green_in;
            r_red1   <= i_red_in;
        end
        if (w_en2) begin
            r_blue2  <= n_blue2;
            r_green2 <= n_green2;
            r_red2   <= n_red2;
        end
        if (w_en3) begin
            r_blue3  <= n_blue3;
            r_green3 <= n_green3;
            r_red3   <= n_red3;
        end
    end

    assign o_valid     = r_v3;
    assign o_blue_out  = r_blue3;
    assign o_green_out = r_green3;
    assign o_red_out   = r_red3;

endmodule

### rtl/core/pcrt_check.sv
// port-level checker for the pixel contrast and red tint block, with its bind
module pcrt_check (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        o_ready,
    input logic                        o_valid,
    input logic                        i_ready,
    input logic [pcrt_pkg::CHAN_W-1:0] o_blue_out,
    input logic [pcrt_pkg::CHAN_W-1:0] o_green_out,
    input logic [pcrt_pkg::CHAN_W-1:0] o_red_out
);
    import pcrt_pkg::*;

    // reset empties the pipe
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("output valid right after reset");

    // empty output register means the whole pipe can take a word
    a_empty_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> o_ready)
        else $error("not ready while output is empty");

    // a draining receiver never stalls the input
    a_drain_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ready |-> o_ready)
        else $error("not ready while receiver takes words");

    // stalled result holds
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_blue_out)
            && $stable(o_green_out) && $stable(o_red_out))
        else $error("stalled output word changed");

endmodule

bind pixel_contrast_and_red_tint pcrt_check u_pcrt_check (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .o_ready(o_ready), .o_valid(o_valid),
    .i_ready(i_ready), .o_blue_out(o_blue_out), .o_green_out(o_green_out),
    .o_red_out(o_red_out)
);

### sim/pcrt_result_check.sv
`timescale 1ns / 1ps
// channel monitor that predicts each filtered pixel and compares it with the block output
module pcrt_result_check (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [pcrt_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [pcrt_pkg::CFG_DAT_W-1:0] i_cfg_data,
    input  logic                           i_in_valid,
    input  logic                           i_in_ready,
    input  logic [pcrt_pkg::CHAN_W-1:0]    i_in_blue,
    input  logic [pcrt_pkg::CHAN_W-1:0]    i_in_green,
    input  logic [pcrt_pkg::CHAN_W-1:0]    i_in_red,
    input  logic                           i_out_valid,
    input  logic                           i_out_ready,
    input  logic [pcrt_pkg::CHAN_W-1:0]    i_out_blue,
    input  logic [pcrt_pkg::CHAN_W-1:0]    i_out_green,
    input  logic [pcrt_pkg::CHAN_W-1:0]    i_out_red,
    output int                             o_pending,
    output int                             o_mismatch_count
);
    import pcrt_pkg::*;

    localparam int unsigned PCT_DIV    = 100;
    localparam int unsigned CHAN_COUNT = 3;
    localparam int          MAX_REPORTS = 10;

    typedef struct packed {
        logic [CHAN_W-1:0] blue;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] red;
    } t_pixel;

    logic              filter_mode;
    logic [PCT_W-1:0]  percent;
    logic [CHAN_W-1:0] mid_level;

    t_pixel expected_pixels[$];

    // v + floor(v*p/100), saturated at full scale
    function automatic logic [CHAN_W-1:0] brighten(input logic [CHAN_W-1:0] v);
        int unsigned sum;
        sum = int'(v) + (int'(v) * int'(percent)) / PCT_DIV;
        return (sum > CHAN_MAX) ? CHAN_MAX : sum[CHAN_W-1:0];
    endfunction

    // v - ceil(v*p/100), clamped at zero
    function automatic logic [CHAN_W-1:0] darken(input logic [CHAN_W-1:0] v);
        int unsigned cut;
        int unsigned diff;
        cut  = (int'(v) * int'(percent) + PCT_DIV - 1) / PCT_DIV;
        diff = int'(v) - cut;
        return (cut >= int'(v)) ? '0 : diff[CHAN_W-1:0];
    endfunction

    function automatic t_pixel adjust_pixel(input t_pixel px);
        int unsigned mean;
        t_pixel      res;
        if (filter_mode == MODE_CONTRAST) begin
            mean = (int'(px.blue) + int'(px.green) + int'(px.red)) / CHAN_COUNT;
            if (mean > mid_level) begin
                res.blue  = brighten(px.blue);
                res.green = brighten(px.green);
                res.red   = brighten(px.red);
            end else begin
                res.blue  = darken(px.blue);
                res.green = darken(px.green);
                res.red   = darken(px.red);
            end
        end else begin
            res.red   = brighten(px.red);
            res.green = darken(px.green);
            res.blue  = darken(px.blue);
        end
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_pixel seen;
        t_pixel want;
        if (!i_rst_n) begin
            filter_mode = MODE_CONTRAST;
            percent     = '0;
            mid_level   = MID_LEVEL_RST;
            expected_pixels.delete();
            o_pending        <= 0;
            o_mismatch_count <= 0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_FILTER_MODE: filter_mode = i_cfg_data[0];
                    CFG_PERCENT:     percent     = i_cfg_data[PCT_W-1:0];
                    CFG_MID_LEVEL:   mid_level   = i_cfg_data[CHAN_W-1:0];
                    default: ;
                endcase
            end
            // retire the output word before queueing the new input word
            if (i_out_valid && i_out_ready) begin
                seen = '{blue: i_out_blue, green: i_out_green, red: i_out_red};
                if (expected_pixels.size() == 0) begin
                    if (o_mismatch_count < MAX_REPORTS)
                        $display("unexpected output word b=%0d g=%0d r=%0d",
                                 seen.blue, seen.green, seen.red);
                    o_mismatch_count <= o_mismatch_count + 1;
                end else begin
                    want = expected_pixels.pop_front();
                    if (seen.blue != want.blue || seen.green != want.green ||
                        seen.red != want.red) begin
                        if (o_mismatch_count < MAX_REPORTS)
                            $display("mismatch: exp b=%0d g=%0d r=%0d, got b=%0d g=%0d r=%0d",
                                     want.blue, want.green, want.red,
                                     seen.blue, seen.green, seen.red);
                        o_mismatch_count <= o_mismatch_count + 1;
                    end
                end
            end
            if (i_in_valid && i_in_ready)
                expected_pixels.push_back(adjust_pixel('{blue: i_in_blue, green: i_in_green,
                                                         red: i_in_red}));
            o_pending <= expected_pixels.size();
        end
    end

endmodule

### sim/pixel_contrast_and_red_tint_tb.sv
`timescale 1ns / 1ps
// stimulus, clock, reset and final verdict for the pixel contrast and red tint filter
module pixel_contrast_and_red_tint_tb;
    import pcrt_pkg::*;

    // generous bound for a run of about 2k words
    localparam int CYCLE_LIMIT     = 200000;
    localparam int WORDS_PER_PHASE = 240;
    localparam int NUM_PHASES      = 8;
    localparam int TAIL_CYCLES     = 10;
    // index past the register list, writes there must be dropped
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    logic                 i_clk      = 1'b0;
    logic                 i_rst_n    = 1'b0;
    logic                 i_cfg_we   = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx  = '0;
    logic [CFG_DAT_W-1:0] i_cfg_data = '0;
    logic                 i_valid    = 1'b0;
    logic [CHAN_W-1:0]    i_blue_in  = '0;
    logic [CHAN_W-1:0]    i_green_in = '0;
    logic [CHAN_W-1:0]    i_red_in   = '0;
    logic                 i_ready    = 1'b0;
    logic                 o_ready;
    logic                 o_valid;
    logic [CHAN_W-1:0]    o_blue_out;
    logic [CHAN_W-1:0]    o_green_out;
    logic [CHAN_W-1:0]    o_red_out;

    int pending_words;
    int mismatch_count;
    int cycle_count = 0;

    // percent chance per cycle of a sender gap / receiver stall
    int gap_pct   = 0;
    int stall_pct = 0;

    // current register settings, used to aim pixels at the contrast threshold
    logic              cur_mode = MODE_CONTRAST;
    logic [CHAN_W-1:0] cur_mid  = MID_LEVEL_RST;

    pixel_contrast_and_red_tint DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_blue_in   (i_blue_in),
        .i_green_in  (i_green_in),
        .i_red_in    (i_red_in),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_blue_out  (o_blue_out),
        .o_green_out (o_green_out),
        .o_red_out   (o_red_out)
    );

    pcrt_result_check u_result_check (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_idx        (i_cfg_idx),
        .i_cfg_data       (i_cfg_data),
        .i_in_valid       (i_valid),
        .i_in_ready       (o_ready),
        .i_in_blue        (i_blue_in),
        .i_in_green       (i_green_in),
        .i_in_red         (i_red_in),
        .i_out_valid      (o_valid),
        .i_out_ready      (i_ready),
        .i_out_blue       (o_blue_out),
        .i_out_green      (o_green_out),
        .i_out_red        (o_red_out),
        .o_pending        (pending_words),
        .o_mismatch_count (mismatch_count)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // receiver side: random backpressure, always ready when stall_pct is zero
    always @(posedge i_clk) begin
        i_ready <= ($urandom_range(99) >= stall_pct);
    end

    // watchdog, a hung handshake ends the run here
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("[pixel_contrast_and_red_tint] ERROR");
            $finish;
        end
    end

    // one pixel word, with random gaps ahead of it, held until accepted
    task automatic send_pixel(input logic [CHAN_W-1:0] b, input logic [CHAN_W-1:0] g,
                              input logic [CHAN_W-1:0] r);
        while ($urandom_range(99) < gap_pct) begin
            i_valid    <= 1'b0;
            i_blue_in  <= CHAN_W'($urandom);
            i_green_in <= CHAN_W'($urandom);
            i_red_in   <= CHAN_W'($urandom);
            @(posedge i_clk);
        end
        i_valid    <= 1'b1;
        i_blue_in  <= b;
        i_green_in <= g;
        i_red_in   <= r;
        do @(posedge i_clk); while (!o_ready);
    endtask

    // single-cycle register write, then the strobe is dropped before the task returns
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    // stop sending and wait for every predicted word to come out
    task automatic drain_pipe();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (pending_words != 0);
    endtask

    // all three registers, with random junk in the bits above each width
    task automatic set_filter(input logic mode, input logic [PCT_W-1:0] pct,
                              input logic [CHAN_W-1:0] mid);
        logic [CFG_DAT_W-1:0] junk;
        junk     = CFG_DAT_W'($urandom);
        cur_mode = mode;
        cur_mid  = mid;
        write_reg(CFG_FILTER_MODE, {junk[CFG_DAT_W-1:1], mode});
        write_reg(CFG_PERCENT, {junk[0], pct});
        write_reg(CFG_MID_LEVEL, mid);
    endtask

    initial begin
        int                phase;
        int                n;
        int                sum;
        int                rem;
        logic [CHAN_W-1:0] rv;
        logic [CHAN_W-1:0] gv;
        logic [CHAN_W-1:0] bv;
        logic [PCT_W-1:0]  pct;

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset settings: zero percent, pixels pass through either way
        send_pixel(8'd0, 8'd0, 8'd0);
        send_pixel(8'd255, 8'd255, 8'd255);
        send_pixel(8'd128, 8'd127, 8'd129);
        drain_pipe();

        // 50 percent with bit 7 set, threshold 100, plus a write past the list
        write_reg(CFG_PERCENT, 8'hB2);
        write_reg(CFG_MID_LEVEL, 8'd100);
        write_reg(CFG_UNUSED, 8'hFF);
        send_pixel(8'd100, 8'd100, 8'd100);     // mean on threshold shrinks
        send_pixel(8'd101, 8'd101, 8'd101);     // just above grows
        send_pixel(8'd200, 8'd10, 8'd90);       // mean 100 again, uneven channels
        send_pixel(8'd255, 8'd255, 8'd255);     // grow saturates
        send_pixel(8'd1, 8'd2, 8'd3);           // ceil on tiny values
        drain_pipe();

        // percent above one hundred, threshold at both ends
        set_filter(MODE_CONTRAST, 7'd127, 8'd0);
        send_pixel(8'd0, 8'd0, 8'd0);
        send_pixel(8'd1, 8'd1, 8'd1);
        send_pixel(8'd255, 8'd0, 8'd128);
        drain_pipe();
        set_filter(MODE_CONTRAST, 7'd127, 8'd255);
        send_pixel(8'd255, 8'd255, 8'd255);     // clamps to zero
        send_pixel(8'd254, 8'd255, 8'd255);
        drain_pipe();

        // red tint, mode written with upper bits set
        write_reg(CFG_FILTER_MODE, 8'h03);
        write_reg(CFG_PERCENT, 8'd100);
        send_pixel(8'd255, 8'd255, 8'd255);
        send_pixel(8'd7, 8'd13, 8'd200);
        drain_pipe();
        write_reg(CFG_PERCENT, 8'd1);
        send_pixel(8'd99, 8'd100, 8'd101);
        send_pixel(8'd0, 8'd255, 8'd0);
        drain_pipe();

        for (phase = 0; phase < NUM_PHASES; phase++) begin
            // idling pattern rotates through four flavors
            case (phase % 4)
                0: begin gap_pct = 0;  stall_pct <= 0;  end
                1: begin gap_pct = 50; stall_pct <= 0;  end
                2: begin gap_pct = 0;  stall_pct <= 50; end
                default: begin gap_pct = 18; stall_pct <= 18; end
            endcase

            // first phases pin the extremes, the rest are random
            case (phase)
                0: set_filter(MODE_CONTRAST, 7'd100, 8'd127);
                1: set_filter(MODE_RED_TINT, 7'd127, 8'd0);
                2: set_filter(MODE_CONTRAST, 7'd0, 8'd255);
                3: set_filter(MODE_CONTRAST, 7'd1, 8'd0);
                default: begin
                    pct = PCT_W'(($urandom_range(3) == 0) ? $urandom_range(127, 101)
                                                          : $urandom_range(100, 0));
                    set_filter(1'($urandom_range(1)), pct, CHAN_W'($urandom_range(255)));
                    if ($urandom_range(1))
                        write_reg(CFG_UNUSED, CFG_DAT_W'($urandom));
                end
            endcase

            for (n = 0; n < WORDS_PER_PHASE; n++) begin
                if (cur_mode == MODE_CONTRAST && $urandom_range(2) == 0) begin
                    // channel sum picked so the mean lands on or just above the threshold
                    sum = 3 * cur_mid + $urandom_range(5);
                    if (sum > 765)
                        sum = 765;
                    rv  = CHAN_W'($urandom_range((sum < 255) ? sum : 255,
                                                 (sum > 510) ? sum - 510 : 0));
                    rem = sum - rv;
                    gv  = CHAN_W'($urandom_range((rem < 255) ? rem : 255,
                                                 (rem > 255) ? rem - 255 : 0));
                    bv  = CHAN_W'(rem - gv);
                end else if ($urandom_range(7) == 0) begin
                    // full-scale corners
                    bv = $urandom_range(1) ? 8'd255 : 8'd0;
                    gv = $urandom_range(1) ? 8'd255 : 8'd0;
                    rv = $urandom_range(1) ? 8'd255 : 8'd0;
                end else begin
                    bv = CHAN_W'($urandom);
                    gv = CHAN_W'($urandom);
                    rv = CHAN_W'($urandom);
                end
                send_pixel(bv, gv, rv);

                // let the pipe run dry mid-phase, then resume
                if ((phase == 2 || phase == 5) && n == WORDS_PER_PHASE / 2)
                    drain_pipe();
            end
            drain_pipe();
        end

        // the TAIL_CYCLES wait catches stray output words before the verdict
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("[pixel_contrast_and_red_tint] OK");
        else
            $display("[pixel_contrast_and_red_tint] ERROR");
        $finish;
    end

endmodule
